// ===== sv/mtsg_pkg.sv =====
package mtsg_pkg;

  localparam int TONES           = 2;
  localparam int SINE_TABLE_BITS = 10;
  localparam int MAX_CHANNELS    = 8;

  // configuration holds two tones; cells exist only for tones that can be enabled
  localparam int CFG_TONES = 2;
  localparam int NCELL     = (TONES < CFG_TONES) ? TONES : CFG_TONES;

  localparam int TABLE_N  = 1 << SINE_TABLE_BITS;
  localparam int IDX_W    = SINE_TABLE_BITS + 1;
  localparam int PHASE_W  = 32;
  localparam int AMP_W    = 15;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = SAMPLE_W + $clog2(NCELL) + 1;

  localparam int CELL_LAT   = 4;
  localparam int PIPE_LAT   = CELL_LAT * NCELL;
  localparam int FIFO_AW    = $clog2(PIPE_LAT + 2);
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  localparam int CH_MAX = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;
  localparam int CHAN_W = 3;
  localparam int CCNT_W = 4;
  localparam int TCNT_W = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TONE0_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE0_AMP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TONE0_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TONE1_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TONE1_AMP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TONE1_START  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_COUNT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_CNT  = 3'd7;

  localparam logic [PHASE_W-1:0] TONE0_STEP_RST    = 32'd39187088;
  localparam logic [AMP_W-1:0]   TONE0_AMP_RST     = 15'd3277;
  localparam logic [PHASE_W-1:0] START_RST         = '0;
  localparam logic [TCNT_W-1:0]  TONE_COUNT_RST    = 2'd1;
  localparam logic [CCNT_W-1:0]  CHANNEL_COUNT_RST = 4'd2;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [PHASE_W-1:0] step;
    logic [AMP_W-1:0]   amp;
    logic [PHASE_W-1:0] start;
  } tone_cfg_t;

  typedef struct packed {
    logic                    vld;
    logic                    restart;
    logic signed [SUM_W-1:0] sum;
  } cell_link_t;

  typedef logic [AMP_W-1:0] sine_rom_t [TABLE_N+1];

  // round(32767 * sin(pi/2 * i / N)) through a Q30 Taylor series
  function automatic logic [AMP_W-1:0] sine_entry(input int i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        v;
    x    = (PI_HALF_Q30 * 64'(i)) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    acc  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    acc  = acc + signed'(term);
    if (acc < 0) begin
      acc = '0;
    end
    v = (unsigned'(acc) * 64'd32767 + 64'd536870912) >> 30;
    return (v > 64'd32767) ? {AMP_W{1'b1}} : v[AMP_W-1:0];
  endfunction

  function automatic sine_rom_t sine_rom_init();
    sine_rom_t rom;
    for (int i = 0; i <= TABLE_N; i++) begin
      rom[i] = sine_entry(i);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = sine_rom_init();

endpackage

// ===== sv/mtsg_ifs.sv =====
interface mtsg_in_if import mtsg_pkg::*;;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface mtsg_out_if import mtsg_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [CHAN_W-1:0]          channel;
  logic                       last;

  modport source (output valid, output sample, output channel, output last, input ready);
  modport sink (input valid, input sample, input channel, input last, output ready);
endinterface

// ===== sv/mtsg_cell.sv =====
module mtsg_cell import mtsg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  tone_cfg_t  cfg,
  input  logic       en,
  input  cell_link_t link_i,
  output cell_link_t link_o
);

  logic [PHASE_W-1:0]    phase_r;
  logic [PHASE_W-1:0]    phase_nxt;
  logic [1:0]            quad;
  logic [IDX_W-1:0]      idx_lo;
  logic [IDX_W-1:0]      idx_nxt;

  logic                    v0_r, rs0_r, en0_r, neg0_r;
  logic [IDX_W-1:0]        idx0_r;
  logic signed [SUM_W-1:0] sum0_r;

  logic                    v1_r, rs1_r, en1_r, neg1_r;
  logic [AMP_W-1:0]        rom_r;
  logic signed [SUM_W-1:0] sum1_r;

  logic                    v2_r, rs2_r, neg2_r;
  logic [AMP_W-1:0]        tv_r;
  logic signed [SUM_W-1:0] sum2_r;

  logic [2*AMP_W-1:0]      prod;
  logic signed [SUM_W-1:0] tv_ext;
  cell_link_t              link_r;

  // reload on restart, advance only when the tone is enabled
  assign phase_nxt = (link_i.restart ? cfg.start : phase_r) + (en ? cfg.step : '0);
  assign quad      = phase_nxt[PHASE_W-1 -: 2];
  assign idx_lo    = {1'b0, phase_nxt[PHASE_W-3 -: SINE_TABLE_BITS]};
  assign idx_nxt   = quad[0] ? (IDX_W'(TABLE_N) - idx_lo) : idx_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= START_RST;
    end else if (link_i.vld) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= link_i.vld;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    rs0_r  <= link_i.restart;
    en0_r  <= en;
    neg0_r <= quad[1];
    idx0_r <= idx_nxt;
    sum0_r <= link_i.sum;

    rs1_r  <= rs0_r;
    en1_r  <= en0_r;
    neg1_r <= neg0_r;
    rom_r  <= SINE_ROM[idx0_r];
    sum1_r <= sum0_r;

    rs2_r  <= rs1_r;
    neg2_r <= neg1_r;
    tv_r   <= en1_r ? prod[2*AMP_W-1 -: AMP_W] : '0;
    sum2_r <= sum1_r;
  end

  // magnitude scaled first, so the sign flip gives truncation toward zero
  assign prod   = rom_r * cfg.amp;
  assign tv_ext = signed'({{(SUM_W-AMP_W){1'b0}}, tv_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r.vld <= 1'b0;
    end else begin
      link_r.vld <= v2_r;
    end
    link_r.restart <= rs2_r;
    link_r.sum     <= neg2_r ? (sum2_r - tv_ext) : (sum2_r + tv_ext);
  end

  assign link_o = link_r;

endmodule

// ===== sv/mtsg_emit.sv =====
module mtsg_emit import mtsg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    req_accept,
  input  logic                    frame_vld,
  input  logic signed [SUM_W-1:0] frame_sum,
  input  logic [CCNT_W-1:0]       channel_count,
  output logic                    credit_ok,
  mtsg_out_if.source              out_ch
);

  logic [FIFO_AW:0]           occ_r, occ_nxt;
  logic [FIFO_AW:0]           cnt_r, cnt_nxt;
  logic [FIFO_AW-1:0]         wr_ptr_r, rd_ptr_r;
  logic signed [SAMPLE_W-1:0] mem_r [FIFO_DEPTH];
  logic signed [SAMPLE_W-1:0] sat;

  logic                       ov_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [CHAN_W-1:0]          chan_r;

  logic [CCNT_W-1:0] chans;
  logic [CHAN_W-1:0] last_ch;
  logic              is_last, fin, adv, load;

  always_comb begin
    if (frame_sum > SUM_W'(32767)) begin
      sat = 16'sh7fff;
    end else if (frame_sum < -SUM_W'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = frame_sum[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    if (channel_count == '0) begin
      chans = CCNT_W'(1);
    end else if (channel_count > CCNT_W'(CH_MAX)) begin
      chans = CCNT_W'(CH_MAX);
    end else begin
      chans = channel_count;
    end
  end

  assign last_ch = CHAN_W'(chans - CCNT_W'(1));
  assign is_last = (chan_r == last_ch);
  assign fin     = ov_r && out_ch.ready && is_last;
  assign adv     = ov_r && out_ch.ready && !is_last;
  assign load    = (cnt_r != '0) && (!ov_r || fin);

  // count requests from acceptance until their frame leaves the buffer
  assign occ_nxt   = occ_r + (FIFO_AW+1)'(req_accept) - (FIFO_AW+1)'(load);
  assign cnt_nxt   = cnt_r + (FIFO_AW+1)'(frame_vld) - (FIFO_AW+1)'(load);
  assign credit_ok = (occ_r < (FIFO_AW+1)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= '0;
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      ov_r     <= 1'b0;
      chan_r   <= '0;
    end else begin
      occ_r <= occ_nxt;
      cnt_r <= cnt_nxt;
      if (frame_vld) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (load) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
        ov_r     <= 1'b1;
        chan_r   <= '0;
      end else if (fin) begin
        ov_r <= 1'b0;
      end else if (adv) begin
        chan_r <= chan_r + CHAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_vld) begin
      mem_r[wr_ptr_r] <= sat;
    end
    if (load) begin
      sample_r <= mem_r[rd_ptr_r];
    end
  end

  assign out_ch.valid   = ov_r;
  assign out_ch.sample  = sample_r;
  assign out_ch.channel = chan_r;
  assign out_ch.last    = is_last;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    frame_vld |-> cnt_r < (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("frame buffer overflow");

  a_buf_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= occ_r)
    else $error("buffered frames exceed outstanding requests");

  a_chan_advance: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> ov_r && (chan_r == $past(chan_r) + CHAN_W'(1)))
    else $error("channel index did not advance");

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> chan_r <= last_ch)
    else $error("channel index past frame end");

endmodule

// ===== sv/multi_tone_sine_generator_unit.sv =====
// Multi-tone sine generator.
// Each request on in_ch (restart bit) produces one frame: every enabled tone
// advances its phase accumulator, reads a quarter-wave sine ROM, scales by its
// amplitude, and the tones are summed and saturated to a 16-bit sample. The
// sample goes out on out_ch once per channel, channel 0 first, with last set
// on the final channel.
// Tones run in a row of cells, one per tone, four stages each (phase update,
// ROM read, scale, accumulate); the partial sum moves cell to cell.
// A request passes through every cell's stages, then the frame buffer and the
// output register before its first result appears on out_ch.
// Throughput: one request per cycle into the cells while in_ch.ready is high;
// the output side drains one result per cycle while out_ch.ready is high, and
// a frame gives min(8, max(1, channel_count)) results.
// A stall on out_ch holds the current result; the frame buffer keeps
// accepting until it and the cells hold as many frames as it has entries,
// then in_ch.ready drops.
// Reset loads the register defaults and clears the phases and buffers.
// Write configuration through cfg_we/cfg_index/cfg_wdata only while idle.
module multi_tone_sine_generator_unit import mtsg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mtsg_in_if.sink               in_ch,
  mtsg_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  tone_cfg_t         tone_cfg_r [CFG_TONES];
  logic [TCNT_W-1:0] tone_count_r;
  logic [CCNT_W-1:0] channel_count_r;

  cell_link_t link [NCELL+1];
  logic       credit_ok;
  logic       accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < CFG_TONES; t++) begin
        tone_cfg_r[t].step  <= (t == 0) ? TONE0_STEP_RST : '0;
        tone_cfg_r[t].amp   <= (t == 0) ? TONE0_AMP_RST : '0;
        tone_cfg_r[t].start <= START_RST;
      end
      tone_count_r    <= TONE_COUNT_RST;
      channel_count_r <= CHANNEL_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TONE0_STEP:  tone_cfg_r[0].step  <= cfg_wdata[PHASE_W-1:0];
        REG_TONE0_AMP:   tone_cfg_r[0].amp   <= cfg_wdata[AMP_W-1:0];
        REG_TONE0_START: tone_cfg_r[0].start <= cfg_wdata[PHASE_W-1:0];
        REG_TONE1_STEP:  tone_cfg_r[1].step  <= cfg_wdata[PHASE_W-1:0];
        REG_TONE1_AMP:   tone_cfg_r[1].amp   <= cfg_wdata[AMP_W-1:0];
        REG_TONE1_START: tone_cfg_r[1].start <= cfg_wdata[PHASE_W-1:0];
        REG_TONE_COUNT:  tone_count_r        <= cfg_wdata[TCNT_W-1:0];
        REG_CHANNEL_CNT: channel_count_r     <= cfg_wdata[CCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = credit_ok;
  assign accept      = in_ch.valid && credit_ok;

  assign link[0].vld     = accept;
  assign link[0].restart = in_ch.restart;
  assign link[0].sum     = '0;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    mtsg_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cfg    (tone_cfg_r[k]),
      .en     (tone_count_r > TCNT_W'(k)),
      .link_i (link[k]),
      .link_o (link[k+1])
    );
  end

  mtsg_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_accept    (accept),
    .frame_vld     (link[NCELL].vld),
    .frame_sum     (link[NCELL].sum),
    .channel_count (channel_count_r),
    .credit_ok     (credit_ok),
    .out_ch        (out_ch)
  );

endmodule

// ===== tb/multi_tone_sine_generator_unit_tb.sv =====
module multi_tone_sine_generator_unit_tb import mtsg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES      = 150;
  localparam int DRAIN_CYCLES     = 20;
  localparam int STUCK_LIMIT      = 2000;
  localparam int RANDOM_ROUNDS    = 8;
  localparam int FRAMES_PER_ROUND = 50;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          channel;
    logic                       last;
  } chan_sample_t;

  class sine_frame_checker;
    int unsigned        sine_lut [TABLE_N+1];
    logic [PHASE_W-1:0] step [CFG_TONES];
    logic [AMP_W-1:0]   amp [CFG_TONES];
    logic [PHASE_W-1:0] start_phase [CFG_TONES];
    logic [PHASE_W-1:0] phase_acc [CFG_TONES];
    logic [TCNT_W-1:0]  tone_count;
    logic [CCNT_W-1:0]  channel_count;
    chan_sample_t       expected_samples [$];
    int                 mismatches;

    function new();
      for (int i = 0; i <= TABLE_N; i++) begin
        sine_lut[i] = quarter_sine(i);
      end
      mismatches = 0;
      reset_state();
    endfunction

    // Q30 Taylor series of sin(pi/2 * i / N), scaled to 32767 and rounded half up
    function int unsigned quarter_sine(int unsigned i);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned v;
      longint          acc;
      x    = (PI_HALF_Q30 * i) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      acc  = x;
      for (int k = 1; k <= 6; k++) begin
        term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      v = (unsigned'(acc) * 32767 + 64'd536870912) >> 30;
      return (v > 32767) ? 32767 : v[AMP_W-1:0];
    endfunction

    function int signed_sine(logic [PHASE_W-1:0] ph);
      logic [SINE_TABLE_BITS-1:0] i;
      int unsigned                idx;
      i   = ph[29 -: SINE_TABLE_BITS];
      idx = ph[30] ? TABLE_N - i : i;
      return ph[31] ? -int'(sine_lut[idx]) : int'(sine_lut[idx]);
    endfunction

    function void reset_state();
      step[0]        = TONE0_STEP_RST;
      amp[0]         = TONE0_AMP_RST;
      start_phase[0] = START_RST;
      step[1]        = '0;
      amp[1]         = '0;
      start_phase[1] = START_RST;
      tone_count     = TONE_COUNT_RST;
      channel_count  = CHANNEL_COUNT_RST;
      for (int t = 0; t < CFG_TONES; t++) begin
        phase_acc[t] = start_phase[t];
      end
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_TONE0_STEP:  step[0] = val;
        REG_TONE0_AMP:   amp[0] = val[AMP_W-1:0];
        REG_TONE0_START: start_phase[0] = val;
        REG_TONE1_STEP:  step[1] = val;
        REG_TONE1_AMP:   amp[1] = val[AMP_W-1:0];
        REG_TONE1_START: start_phase[1] = val;
        REG_TONE_COUNT:  tone_count = val[TCNT_W-1:0];
        REG_CHANNEL_CNT: channel_count = val[CCNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_frame(logic restart);
      longint       sum;
      int           tones;
      int           chans;
      chan_sample_t s;
      if (restart) begin
        for (int t = 0; t < CFG_TONES; t++) begin
          phase_acc[t] = start_phase[t];
        end
      end
      tones = tone_count;
      if (tones > TONES) tones = TONES;
      if (tones > CFG_TONES) tones = CFG_TONES;
      sum = 0;
      // disabled tones hold their phase
      for (int t = 0; t < tones; t++) begin
        phase_acc[t] = phase_acc[t] + step[t];
        sum += (longint'(signed_sine(phase_acc[t])) * longint'(amp[t])) / 32768;
      end
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      chans = channel_count;
      if (chans == 0) chans = 1;
      if (chans > CH_MAX) chans = CH_MAX;
      for (int c = 0; c < chans; c++) begin
        s.sample  = 16'(sum);
        s.channel = CHAN_W'(c);
        s.last    = (c == chans - 1);
        expected_samples.insert(expected_samples.size(), s);
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 20) begin
        $display("mismatch at %0t: %s", $time, what);
      end
    endtask

    task check_sample(logic signed [SAMPLE_W-1:0] sample, logic [CHAN_W-1:0] channel,
                      logic last);
      chan_sample_t e;
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("sample %0d on channel %0d with no request pending",
                                  sample, channel));
        return;
      end
      e = expected_samples.pop_front();
      if (sample !== e.sample) begin
        report_mismatch($sformatf("channel %0d: sample %0d, expected %0d",
                                  e.channel, sample, e.sample));
      end
      if (channel !== e.channel) begin
        report_mismatch($sformatf("channel %0d, expected %0d", channel, e.channel));
      end
      if (last !== e.last) begin
        report_mismatch($sformatf("channel %0d: last %0b, expected %0b",
                                  e.channel, last, e.last));
      end
    endtask

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  idle_en = 1'b1;
  logic                  hold_req = 1'b0;
  int                    stuck_cycles = 0;
  sine_frame_checker     frames;

  mtsg_in_if  in_ch ();
  mtsg_out_if out_ch ();

  multi_tone_sine_generator_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        frames.predict_frame(in_ch.restart);
      end
      if (out_ch.valid && out_ch.ready) begin
        frames.check_sample(out_ch.sample, out_ch.channel, out_ch.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stall bursts, quiet stretches, and one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req     <= 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 15) == 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(10, 30)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task send_request(logic restart);
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task send_frames(int count, int restart_odds);
    for (int n = 0; n < count; n++) begin
      if (idle_en && $urandom_range(0, 3) == 0) begin
        in_ch.valid   <= 1'b0;
        in_ch.restart <= 1'($urandom);
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      send_request($urandom_range(0, restart_odds - 1) == 0);
    end
    in_ch.valid <= 1'b0;
  endtask

  task settle();
    while (frames.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    frames.apply_register(idx, val);
  endtask

  task program_tones(logic [31:0] step0, logic [31:0] amp0, logic [31:0] start0,
                     logic [31:0] step1, logic [31:0] amp1, logic [31:0] start1,
                     logic [31:0] tones, logic [31:0] chans);
    write_register(REG_TONE0_STEP, step0);
    write_register(REG_TONE0_AMP, amp0);
    write_register(REG_TONE0_START, start0);
    write_register(REG_TONE1_STEP, step1);
    write_register(REG_TONE1_AMP, amp1);
    write_register(REG_TONE1_START, start1);
    write_register(REG_TONE_COUNT, tones);
    write_register(REG_CHANNEL_CNT, chans);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1 << 24);
      1:       return $urandom;
      2:       return 32'h8000_0000;
      default: return $urandom_range(0, 32'h8000_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_amp();
    case ($urandom_range(0, 5))
      0:       return 32767;
      1:       return 0;
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  initial begin
    frames        = new();
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_TONE0_STEP;
    cfg_wdata     = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults after reset
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    in_ch.valid <= 1'b0;
    settle();

    // both tones at full scale near -1: negative saturation, eight channels
    program_tones(32'h8000_0000, 32767, 32'h4000_0000, 32'hFFFF_FFFF, 32767, 32'hC000_0000,
                  2, 8);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    in_ch.valid <= 1'b0;
    settle();

    // both tones parked at the positive peak: positive saturation, one channel
    program_tones(0, 32767, 32'h4000_0000, 0, 32767, 32'h4000_0000, 2, 1);
    send_request(1'b1);
    send_request(1'b0);
    in_ch.valid <= 1'b0;
    settle();

    // no tone enabled, zero channels
    program_tones(32'h1234_5678, 0, 0, 32'h0100_0000, 0, 0, 0, 0);
    send_request(1'b0);
    send_request(1'b1);
    in_ch.valid <= 1'b0;
    settle();

    // tone and channel counts over the cap; new start phases wait for restart
    program_tones(32'h7FFF_FFFF, 32767, 0, 32'h0010_0000, 16384, 32'hFFFF_FFFF, 3, 15);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    in_ch.valid <= 1'b0;
    settle();

    // single tone, step past half a turn, tone 1 must hold its phase
    program_tones(32'hFFF0_0000, 1, 32'h2000_0000, 1, 32767, 0, 1, 7);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    in_ch.valid <= 1'b0;
    settle();

    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      program_tones(pick_step(), pick_amp(), $urandom, pick_step(), pick_amp(), $urandom,
                    $urandom_range(0, 3), $urandom_range(0, 15));
      if (r == 0) begin
        hold_req <= 1'b1;
      end
      if (r == RANDOM_ROUNDS - 1) begin
        idle_en <= 1'b0;
      end
      send_frames(FRAMES_PER_ROUND, 6);
      settle();
    end

    if (frames.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
